### src/gecp_pkg.sv
// gecp_pkg: shared widths, codes and control types for the graph eccentricity unit
// no dependencies
package gecp_pkg;
   localparam int MAX_NODES_DEF = 64;
   localparam int NODE_W        = 7;
   localparam int ECC_W         = 6;
   localparam int ACT_W         = 2;
   localparam int MASK_W        = 64;

   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;
   localparam logic [ECC_W-1:0]  ECC_MAX        = 6'd63;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } adj_cmd_type;
endpackage

### src/gecp_adj_mem.sv
// gecp_adj_mem: adjacency row memory, one row per node, with per-row valid bits
// depends on gecp_pkg
module gecp_adj_mem
   import gecp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  adj_cmd_type                  cmd,
   input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
   input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
   input  logic [MAX_NODES-1:0]         wr_data,
   output logic [MAX_NODES-1:0]         rd_row
);
   logic [MAX_NODES-1:0] mem [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;
endmodule

### src/gecp_ecc_mem.sv
// gecp_ecc_mem: per-node eccentricity memory, one write and one registered read port
// depends on gecp_pkg
module gecp_ecc_mem
   import gecp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
   input  logic [ECC_W-1:0]             wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
   output logic [ECC_W-1:0]             rd_data
);
   logic [ECC_W-1:0] mem [MAX_NODES];
   logic [ECC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/graph_eccentricity_center_periphery_unit.sv
// graph_eccentricity_center_periphery_unit: top level, control sequencer and result register
// depends on gecp_pkg, gecp_adj_mem, gecp_ecc_mem
// add edge item: read-modify-write of both rows; clear item: invalidates all rows
// run item: a level-by-level search from each source, then a mask pass and output,
// with one adjacency row read per cycle per search level
// one item at a time; a finished result waits in the output register
// synchronous reset empties the graph and sets node_count to 64
module graph_eccentricity_center_periphery_unit
   import gecp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ECC_W-1:0]  rsp_diameter,
   output logic [ECC_W-1:0]  rsp_radius,
   output logic [MASK_W-1:0] rsp_center_mask,
   output logic [MASK_W-1:0] rsp_periphery_mask,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_node_count
);
   localparam int IDX_W = $clog2(MAX_NODES);
   localparam logic [NODE_W-1:0] MAX_N = NODE_W'(MAX_NODES);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ADD_A  = 4'd1;
   localparam logic [3:0] ST_ADD_WA = 4'd2;
   localparam logic [3:0] ST_ADD_B  = 4'd3;
   localparam logic [3:0] ST_ADD_WB = 4'd4;
   localparam logic [3:0] ST_SRC    = 4'd5;
   localparam logic [3:0] ST_SCAN   = 4'd6;
   localparam logic [3:0] ST_MASK   = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [NODE_W-1:0]    node_count_ff;
   logic [NODE_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [NODE_W-1:0]    src_ff, src_in;
   logic [NODE_W-1:0]    scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] frontier_ff, frontier_in;
   logic [MAX_NODES-1:0] next_ff, next_in;
   logic [ECC_W-1:0]     level_ff, level_in;
   logic [ECC_W-1:0]     dmax_ff, dmax_in, rmin_ff, rmin_in;
   logic [MAX_NODES-1:0] center_ff, center_in, peri_ff, peri_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ECC_W-1:0]     rsp_dia_ff, rsp_dia_in, rsp_rad_ff, rsp_rad_in;
   logic [MAX_NODES-1:0] rsp_cen_ff, rsp_cen_in, rsp_per_ff, rsp_per_in;

   logic [NODE_W-1:0]    n_eff;
   logic [MAX_NODES-1:0] inuse;
   logic [MAX_NODES-1:0] row;
   logic [MAX_NODES-1:0] acc_now;
   logic [MAX_NODES-1:0] fresh;
   logic                 issue;
   logic [ECC_W-1:0]     ecc_rd;
   adj_cmd_type          adj_cmd;
   logic [IDX_W-1:0]     adj_rd_addr, adj_wr_addr;
   logic [MAX_NODES-1:0] adj_wr_data;
   logic                 ecc_wr_en, ecc_rd_en;

   always_comb begin
      n_eff = node_count_ff;
      if (node_count_ff == '0) begin
         n_eff = NODE_W'(1);
      end else if (node_count_ff > MAX_N) begin
         n_eff = MAX_N;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         inuse[i] = NODE_W'(i) < n_ff;
      end
   end

   assign issue   = scan_ff < n_ff;
   assign acc_now = next_ff | ((pend_ff && frontier_ff[pend_idx_ff]) ? row : '0);
   assign fresh   = acc_now & inuse & ~visited_ff;

   gecp_adj_mem #(.MAX_NODES(MAX_NODES)) u_adj (
      .clock   (clock),
      .reset   (reset),
      .cmd     (adj_cmd),
      .rd_addr (adj_rd_addr),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_row  (row)
   );

   gecp_ecc_mem #(.MAX_NODES(MAX_NODES)) u_ecc (
      .clock   (clock),
      .wr_en   (ecc_wr_en),
      .wr_addr (src_ff[IDX_W-1:0]),
      .wr_data (level_ff),
      .rd_en   (ecc_rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (ecc_rd)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      src_in       = src_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = scan_ff[IDX_W-1:0];
      visited_in   = visited_ff;
      frontier_in  = frontier_ff;
      next_in      = next_ff;
      level_in     = level_ff;
      dmax_in      = dmax_ff;
      rmin_in      = rmin_ff;
      center_in    = center_ff;
      peri_in      = peri_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dia_in   = rsp_dia_ff;
      rsp_rad_in   = rsp_rad_ff;
      rsp_cen_in   = rsp_cen_ff;
      rsp_per_in   = rsp_per_ff;
      adj_cmd      = '0;
      adj_rd_addr  = scan_ff[IDX_W-1:0];
      adj_wr_addr  = a_ff;
      adj_wr_data  = row | (MAX_NODES'(1) << b_ff);
      ecc_wr_en    = 1'b0;
      ecc_rd_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = n_eff;
               a_in = IDX_W'(req_node_a - NODE_W'(1));
               b_in = IDX_W'(req_node_b - NODE_W'(1));
               case (req_action)
                  ACT_ADD: begin
                     if (req_node_a != '0 && req_node_a <= n_eff &&
                         req_node_b != '0 && req_node_b <= n_eff) begin
                        state_in = ST_ADD_A;
                     end
                  end
                  ACT_RUN: begin
                     src_in   = '0;
                     dmax_in  = '0;
                     rmin_in  = ECC_MAX;
                     state_in = ST_SRC;
                  end
                  ACT_CLEAR: begin
                     adj_cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_A: begin
            adj_cmd.rd_en = 1'b1;
            adj_rd_addr   = a_ff;
            state_in      = ST_ADD_WA;
         end
         ST_ADD_WA: begin
            adj_cmd.wr_en = 1'b1;
            state_in      = ST_ADD_B;
         end
         ST_ADD_B: begin
            adj_cmd.rd_en = 1'b1;
            adj_rd_addr   = b_ff;
            state_in      = ST_ADD_WB;
         end
         ST_ADD_WB: begin
            adj_cmd.wr_en = 1'b1;
            adj_wr_addr   = b_ff;
            adj_wr_data   = row | (MAX_NODES'(1) << a_ff);
            state_in      = ST_IDLE;
         end
         ST_SRC: begin
            visited_in  = MAX_NODES'(1) << src_ff[IDX_W-1:0];
            frontier_in = MAX_NODES'(1) << src_ff[IDX_W-1:0];
            next_in     = '0;
            level_in    = '0;
            scan_in     = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue) begin
               adj_cmd.rd_en = 1'b1;
               pend_in       = 1'b1;
               scan_in       = scan_ff + NODE_W'(1);
               next_in       = acc_now;
            end else if (fresh != '0) begin
               level_in    = level_ff + ECC_W'(1);
               visited_in  = visited_ff | fresh;
               frontier_in = fresh;
               next_in     = '0;
               scan_in     = '0;
            end else begin
               ecc_wr_en = 1'b1;
               if (level_ff > dmax_ff) begin
                  dmax_in = level_ff;
               end
               if (level_ff < rmin_ff) begin
                  rmin_in = level_ff;
               end
               if (src_ff == n_ff - NODE_W'(1)) begin
                  scan_in   = '0;
                  center_in = '0;
                  peri_in   = '0;
                  state_in  = ST_MASK;
               end else begin
                  src_in   = src_ff + NODE_W'(1);
                  state_in = ST_SRC;
               end
            end
         end
         ST_MASK: begin
            if (pend_ff) begin
               if (ecc_rd == rmin_ff) begin
                  center_in[pend_idx_ff] = 1'b1;
               end
               if (ecc_rd == dmax_ff) begin
                  peri_in[pend_idx_ff] = 1'b1;
               end
            end
            if (issue) begin
               ecc_rd_en = 1'b1;
               pend_in   = 1'b1;
               scan_in   = scan_ff + NODE_W'(1);
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dia_in   = dmax_ff;
               rsp_rad_in   = rmin_ff;
               rsp_cen_in   = center_ff;
               rsp_per_in   = peri_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RST;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_valid) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      src_ff      <= src_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      visited_ff  <= visited_in;
      frontier_ff <= frontier_in;
      next_ff     <= next_in;
      level_ff    <= level_in;
      dmax_ff     <= dmax_in;
      rmin_ff     <= rmin_in;
      center_ff   <= center_in;
      peri_ff     <= peri_in;
      rsp_dia_ff  <= rsp_dia_in;
      rsp_rad_ff  <= rsp_rad_in;
      rsp_cen_ff  <= rsp_cen_in;
      rsp_per_ff  <= rsp_per_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_diameter       = rsp_dia_ff;
   assign rsp_radius         = rsp_rad_ff;
   assign rsp_center_mask    = MASK_W'(rsp_cen_ff);
   assign rsp_periphery_mask = MASK_W'(rsp_per_ff);
endmodule

### verif/testbench.sv
// testbench for graph_eccentricity_center_periphery_unit: random graphs, idling and stalls
// depends on gecp_pkg and the unit; predicts diameter, radius, center and periphery
module testbench;
   import gecp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ACT_W-1:0]  action;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
   } graph_cmd_type;

   typedef struct {
      logic [ECC_W-1:0]  diameter;
      logic [ECC_W-1:0]  radius;
      logic [MASK_W-1:0] center;
      logic [MASK_W-1:0] periphery;
   } ecc_summary_type;

   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
   localparam int STALL_LIMIT = 1000000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [ACT_W-1:0]  req_action = ACT_ADD;
   logic [NODE_W-1:0] req_node_a = 0;
   logic [NODE_W-1:0] req_node_b = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [ECC_W-1:0]  rsp_diameter;
   logic [ECC_W-1:0]  rsp_radius;
   logic [MASK_W-1:0] rsp_center_mask;
   logic [MASK_W-1:0] rsp_periphery_mask;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [NODE_W-1:0] csr_node_count = 0;

   graph_cmd_type   pending_cmds[$];
   ecc_summary_type expected_summaries[$];
   logic [MASK_W-1:0] adj_rows[MAX_NODES_DEF];
   logic [NODE_W-1:0] model_count = NODE_COUNT_RST;
   int  error_count = 0;
   int  send_idle = 0;
   int  recv_idle = 0;
   int  recv_hold = 0;
   bit  send_hold = 0;
   bit  req_taken = 0;
   int  csr_writes = 0;
   int  idle_cycles = 0;
   int  cmd_total = 0;

   graph_eccentricity_center_periphery_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_node_a(req_node_a), .req_node_b(req_node_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_diameter(rsp_diameter),
      .rsp_radius(rsp_radius), .rsp_center_mask(rsp_center_mask),
      .rsp_periphery_mask(rsp_periphery_mask),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_node_count(csr_node_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task apply_item(graph_cmd_type c);
      int n, s, i;
      logic [MASK_W-1:0] inuse, vis, front, nxt;
      logic [ECC_W-1:0]  lvl;
      logic [ECC_W-1:0]  ecc[MAX_NODES_DEF];
      ecc_summary_type r;
      bit done;
      n = (model_count == 0) ? 1 : (model_count > MAX_NODES_DEF) ? MAX_NODES_DEF : model_count;
      inuse = (n >= 64) ? '1 : ((64'd1 << n) - 1);
      if (c.action == ACT_ADD) begin
         if (c.a >= 1 && c.a <= n && c.b >= 1 && c.b <= n) begin
            adj_rows[c.a-1][c.b-1] = 1'b1;
            adj_rows[c.b-1][c.a-1] = 1'b1;
         end
      end else if (c.action == ACT_CLEAR) begin
         foreach (adj_rows[k]) adj_rows[k] = '0;
      end else if (c.action == ACT_RUN) begin
         r.diameter = 0;
         r.radius = ECC_MAX;
         r.center = 0;
         r.periphery = 0;
         for (s = 0; s < n; s++) begin
            vis = 64'd1 << s;
            front = vis;
            lvl = 0;
            done = 0;
            while (!done) begin
               nxt = 0;
               for (i = 0; i < n; i++) if (front[i]) nxt |= adj_rows[i];
               nxt &= inuse & ~vis;
               if (nxt == 0) done = 1;
               else begin
                  lvl++;
                  vis |= nxt;
                  front = nxt;
               end
            end
            ecc[s] = lvl;
            if (lvl > r.diameter) r.diameter = lvl;
            if (lvl < r.radius) r.radius = lvl;
         end
         for (s = 0; s < n; s++) begin
            if (ecc[s] == r.radius) r.center[s] = 1'b1;
            if (ecc[s] == r.diameter) r.periphery[s] = 1'b1;
         end
         expected_summaries.insert(expected_summaries.size(), r);
      end
   endtask

   // driver
   always @(negedge clock) begin
      graph_cmd_type c;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         if (pending_cmds.size() > 0 && !send_hold && $urandom_range(99) >= send_idle) begin
            c = pending_cmds[0];
            pending_cmds.delete(0);
            req_valid <= 1;
            req_action <= c.action;
            req_node_a <= c.a;
            req_node_b <= c.b;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      graph_cmd_type c;
      ecc_summary_type e;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready || rsp_valid && rsp_ready || csr_valid && csr_ready)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (csr_valid && csr_ready) begin
            model_count = csr_node_count;
            csr_writes <= csr_writes + 1;
         end
         if (req_valid && req_ready) begin
            c.action = req_action;
            c.a = req_node_a;
            c.b = req_node_b;
            apply_item(c);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_summaries.size() == 0) begin
               report("result with nothing expected");
            end else begin
               e = expected_summaries[0];
               expected_summaries.delete(0);
               if (rsp_diameter !== e.diameter)
                  report($sformatf("diameter %0d, expected %0d", rsp_diameter, e.diameter));
               if (rsp_radius !== e.radius)
                  report($sformatf("radius %0d, expected %0d", rsp_radius, e.radius));
               if (rsp_center_mask !== e.center)
                  report($sformatf("center %h, expected %h", rsp_center_mask, e.center));
               if (rsp_periphery_mask !== e.periphery)
                  report($sformatf("periphery %h, expected %h",
                                   rsp_periphery_mask, e.periphery));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task push_cmd(logic [ACT_W-1:0] act, int a, int b);
      graph_cmd_type c;
      c.action = act;
      c.a = NODE_W'(a);
      c.b = NODE_W'(b);
      pending_cmds.insert(pending_cmds.size(), c);
      if (act != ACT_NONE) cmd_total++;
   endtask

   task wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() > 0 || req_valid || expected_summaries.size() > 0);
      repeat (8) @(negedge clock);
   endtask

   task write_count(int v);
      int seen;
      wait_idle();
      seen = csr_writes;
      csr_valid <= 1;
      csr_node_count <= NODE_W'(v);
      do @(negedge clock);
      while (csr_writes == seen);
      csr_valid <= 0;
   endtask

   // one random graph and a run, or else one stray command, with some noise and broken sequences
   task gen_graph(int n);
      int k, j, a, b;
      bit chain;
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0: push_cmd(ACT_NONE, $urandom, $urandom);
            1: push_cmd(ACT_ADD, $urandom, $urandom);
            default: push_cmd(ACT_CLEAR, $urandom, $urandom);
         endcase
         return;
      end
      if ($urandom_range(2) != 0) push_cmd(ACT_CLEAR, $urandom, $urandom);
      k = $urandom_range(0, (2 * n < 30) ? 2 * n : 30);
      chain = $urandom_range(1);
      for (j = 0; j < k; j++) begin
         if ($urandom_range(99) < 10) begin
            a = $urandom_range(127);
            b = $urandom_range(127);
         end else if (chain) begin
            a = $urandom_range(1, n);
            b = (a < n) ? a + 1 : a;
         end else begin
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
         end
         push_cmd(ACT_ADD, a, b);
      end
      push_cmd(ACT_RUN, $urandom, $urandom);
   endtask

   initial begin
      int counts[9] = '{64, 8, 127, 2, 16, 5, 100, 12, 3};
      int p, target, j;
      foreach (adj_rows[k]) adj_rows[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      push_cmd(ACT_RUN, 0, 0);
      push_cmd(ACT_ADD, 1, 64);
      push_cmd(ACT_ADD, 64, 64);
      push_cmd(ACT_ADD, 64, 1);
      push_cmd(ACT_ADD, 0, 5);
      push_cmd(ACT_ADD, 65, 3);
      push_cmd(ACT_ADD, 127, 127);
      push_cmd(ACT_NONE, 127, 127);
      push_cmd(ACT_ADD, 2, 3);
      push_cmd(ACT_RUN, 0, 0);
      push_cmd(ACT_CLEAR, 0, 0);
      push_cmd(ACT_RUN, 127, 127);
      push_cmd(ACT_ADD, 1, 2);
      push_cmd(ACT_ADD, 2, 3);
      push_cmd(ACT_ADD, 3, 4);
      write_count(1);
      push_cmd(ACT_RUN, 0, 0);
      push_cmd(ACT_ADD, 1, 1);
      push_cmd(ACT_ADD, 1, 2);
      push_cmd(ACT_RUN, 0, 0);
      write_count(0);
      push_cmd(ACT_RUN, 0, 0);

      for (p = 0; p < 9; p++) begin
         write_count(counts[p]);
         send_idle = (p < 3) ? 16 : (p < 6) ? 49 : 0;
         recv_idle = (p < 3) ? 49 : (p < 6) ? 16 : 0;
         if (p == 4) begin
            for (j = 0; j < 8; j++) push_cmd(ACT_RUN, 0, 0);
            @(negedge clock);
            recv_hold = 3000;
         end
         if (p == 7) begin
            for (j = 0; j < 5; j++) gen_graph(counts[p]);
            send_hold = 1;
            do @(negedge clock);
            while (expected_summaries.size() > 0 || req_valid && !req_taken);
            send_hold = 0;
         end
         target = cmd_total + 155;
         while (cmd_total < target) begin
            gen_graph(counts[p] > MAX_NODES_DEF ? MAX_NODES_DEF : counts[p]);
            while (pending_cmds.size() > 40) @(negedge clock);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
